[rtl/ntsrw_pkg.sv]
// Shared types, constants and lookup functions for the number to
// seven-segment register write block. No dependencies.
package ntsrw_pkg;

  localparam int DIGITS_DEF = 8;
  localparam int NINIT      = 5;
  localparam int ADDR_W     = 4;
  localparam int DATA_W     = 8;

  localparam logic [1:0] MODE_BLANK = 2'd0;
  localparam logic [1:0] MODE_FULL  = 2'd1;
  localparam logic [1:0] MODE_DOT   = 2'd2;

  localparam logic [ADDR_W-1:0] ADDR_DECODE    = 4'h9;
  localparam logic [ADDR_W-1:0] ADDR_INTENSITY = 4'hA;
  localparam logic [ADDR_W-1:0] ADDR_SCANLIM   = 4'hB;
  localparam logic [ADDR_W-1:0] ADDR_SHUTDOWN  = 4'hC;
  localparam logic [ADDR_W-1:0] ADDR_TEST      = 4'hF;

  localparam logic [DATA_W-1:0] DOT_BIT       = 8'h80;
  localparam logic [DATA_W-1:0] INTENSITY_VAL = 8'h2A;

  // Reciprocal of ten: q = (n * RECIP10) >> QSHIFT is exact for 32-bit n.
  localparam logic [63:0] RECIP10 = 64'h0000_0000_CCCC_CCCD;
  localparam int          QSHIFT  = 35;

  typedef struct packed {
    logic show_init;
    logic show_all;
    logic with_dot;
  } ntsrw_flags_t;

  function automatic logic [DATA_W-1:0] seg_code(input logic [3:0] digit);
    logic [DATA_W-1:0] code;
    case (digit)
      4'd0: code = 8'h7E;
      4'd1: code = 8'h30;
      4'd2: code = 8'h6D;
      4'd3: code = 8'h79;
      4'd4: code = 8'h33;
      4'd5: code = 8'h5B;
      4'd6: code = 8'h5F;
      4'd7: code = 8'h70;
      4'd8: code = 8'h7F;
      4'd9: code = 8'h7B;
      default: code = 8'h00;
    endcase
    return code;
  endfunction

  function automatic logic [ADDR_W-1:0] init_addr(input logic [2:0] idx);
    logic [ADDR_W-1:0] addr;
    case (idx)
      3'd0: addr = ADDR_TEST;
      3'd1: addr = ADDR_SCANLIM;
      3'd2: addr = ADDR_DECODE;
      3'd3: addr = ADDR_INTENSITY;
      3'd4: addr = ADDR_SHUTDOWN;
      default: addr = ADDR_TEST;
    endcase
    return addr;
  endfunction

  function automatic logic [DATA_W-1:0] init_data(input logic [2:0] idx);
    logic [DATA_W-1:0] data;
    case (idx)
      3'd1: data = 8'h07;
      3'd3: data = INTENSITY_VAL;
      3'd4: data = 8'h01;
      default: data = 8'h00;
    endcase
    return data;
  endfunction

endpackage

[rtl/ntsrw_bcd_pipe.sv]
// Binary to decimal digit pipeline: two register stages per digit
// (reciprocal multiply, then remainder and blanking). Uses ntsrw_pkg.
module ntsrw_bcd_pipe import ntsrw_pkg::*; #(
  parameter int DIGITS = DIGITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  output logic                    ready_o,
  input  logic [31:0]             value_i,
  input  logic [1:0]              mode_i,
  output logic                    valid_o,
  input  logic                    ready_i,
  output logic [DIGITS-1:0][3:0]  digits_o,
  output logic [DIGITS-1:0]       shown_o,
  output ntsrw_flags_t            flags_o
);

  localparam int NST = 2 * DIGITS;

  logic [NST:0]   st_valid_q;
  logic [NST:0]   st_valid_d;
  logic [NST+1:0] en;

  logic [31:0]            st_num_q   [0:NST];
  logic [31:0]            st_num_d   [0:NST];
  logic [31:0]            st_quo_q   [0:NST];
  logic [31:0]            st_quo_d   [0:NST];
  logic [DIGITS-1:0][3:0] st_dig_q   [0:NST];
  logic [DIGITS-1:0][3:0] st_dig_d   [0:NST];
  logic [DIGITS-1:0]      st_shown_q [0:NST];
  logic [DIGITS-1:0]      st_shown_d [0:NST];
  logic                   st_blank_q [0:NST];
  logic                   st_blank_d [0:NST];
  ntsrw_flags_t           st_flags_q [0:NST];
  ntsrw_flags_t           st_flags_d [0:NST];

  // A stage takes new data when it is empty or its content moves on.
  assign en[NST+1] = ready_i;
  for (genvar k = 0; k <= NST; k++) begin : g_en
    assign en[k] = !st_valid_q[k] || en[k+1];
  end
  assign ready_o = en[0];

  assign st_valid_d[0] = valid_i;
  for (genvar k = 1; k <= NST; k++) begin : g_vld
    assign st_valid_d[k] = st_valid_q[k-1];
  end

  always_comb begin
    st_num_d[0]             = value_i;
    st_quo_d[0]             = '0;
    st_dig_d[0]             = '0;
    st_shown_d[0]           = '0;
    st_blank_d[0]           = 1'b0;
    st_flags_d[0].with_dot  = (mode_i == MODE_DOT);
    st_flags_d[0].show_all  = (mode_i == MODE_FULL);
    st_flags_d[0].show_init = (mode_i != MODE_DOT);
  end

  for (genvar g = 1; g <= NST; g++) begin : g_stage
    if (g % 2 == 1) begin : g_mul
      logic [63:0] prod;
      assign prod = 64'(st_num_q[g-1]) * RECIP10;
      always_comb begin
        st_num_d[g]   = st_num_q[g-1];
        st_quo_d[g]   = 32'(prod[63:QSHIFT]);
        st_dig_d[g]   = st_dig_q[g-1];
        st_shown_d[g] = st_shown_q[g-1];
        st_blank_d[g] = st_blank_q[g-1];
        st_flags_d[g] = st_flags_q[g-1];
      end
    end else begin : g_rem
      localparam int DI = g / 2 - 1;
      logic [31:0] rem;
      assign rem = st_num_q[g-1] - ((st_quo_q[g-1] << 3) + (st_quo_q[g-1] << 1));
      always_comb begin
        st_num_d[g]       = st_quo_q[g-1];
        st_quo_d[g]       = '0;
        st_dig_d[g]       = st_dig_q[g-1];
        st_dig_d[g][DI]   = rem[3:0];
        st_shown_d[g]     = st_shown_q[g-1];
        st_shown_d[g][DI] = !st_blank_q[g-1];
        // Once the higher part is zero, every higher position is blank unless all digits are shown.
        st_blank_d[g]     = st_blank_q[g-1] ||
                            (!st_flags_q[g-1].show_all && (st_quo_q[g-1] == '0));
        st_flags_d[g]     = st_flags_q[g-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_valid_q <= '0;
    end else begin
      for (int k = 0; k <= NST; k++) begin
        if (en[k]) begin
          st_valid_q[k] <= st_valid_d[k];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k <= NST; k++) begin
      if (en[k]) begin
        st_num_q[k]   <= st_num_d[k];
        st_quo_q[k]   <= st_quo_d[k];
        st_dig_q[k]   <= st_dig_d[k];
        st_shown_q[k] <= st_shown_d[k];
        st_blank_q[k] <= st_blank_d[k];
        st_flags_q[k] <= st_flags_d[k];
      end
    end
  end

  assign valid_o  = st_valid_q[NST];
  assign digits_o = st_dig_q[NST];
  assign shown_o  = st_shown_q[NST];
  assign flags_o  = st_flags_q[NST];

endmodule

[rtl/number_to_segment_register_writes.sv]
// An accepted item passes the digit pipeline registers and the writer's item registers before its first write.
// Throughput: one write per cycle while out_ready_i is high; an item is NINIT+DIGITS writes (13) with the
// control writes and DIGITS writes (8) in dotted mode, all through the single output port.
// The digit pipeline holds 2*DIGITS+1 items while the writer drains the current one.
// Reset clears all valid bits and the writer state; no clearing pass is needed.
// Uses ntsrw_pkg and ntsrw_bcd_pipe.
module number_to_segment_register_writes import ntsrw_pkg::*; #(
  parameter int DIGITS = DIGITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [31:0]       value_i,
  input  logic [1:0]        mode_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [ADDR_W-1:0] reg_address_o,
  output logic [DATA_W-1:0] reg_data_o,
  output logic              last_o
);

  localparam int TOTAL = NINIT + DIGITS;
  localparam int IW    = $clog2(TOTAL + 1);

  logic                   pipe_valid;
  logic                   pipe_ready;
  logic [DIGITS-1:0][3:0] pipe_digits;
  logic [DIGITS-1:0]      pipe_shown;
  ntsrw_flags_t           pipe_flags;

  ntsrw_bcd_pipe #(
    .DIGITS (DIGITS)
  ) u_bcd_pipe (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (in_valid_i),
    .ready_o  (in_ready_o),
    .value_i  (value_i),
    .mode_i   (mode_i),
    .valid_o  (pipe_valid),
    .ready_i  (pipe_ready),
    .digits_o (pipe_digits),
    .shown_o  (pipe_shown),
    .flags_o  (pipe_flags)
  );

  logic                   busy_q, busy_d;
  logic [IW-1:0]          idx_q, idx_d;
  logic [DIGITS-1:0][3:0] item_dig_q, item_dig_d;
  logic [DIGITS-1:0]      item_shown_q, item_shown_d;
  ntsrw_flags_t           item_flags_q, item_flags_d;

  logic              out_valid_q, out_valid_d;
  logic [ADDR_W-1:0] out_addr_q, out_addr_d;
  logic [DATA_W-1:0] out_data_q, out_data_d;
  logic              out_last_q, out_last_d;

  logic out_adv;
  logic emit;
  logic is_last;
  logic is_init;
  logic take;

  assign out_adv    = !out_valid_q || out_ready_i;
  assign emit       = busy_q && out_adv;
  assign is_last    = (idx_q == IW'(TOTAL - 1));
  assign is_init    = (idx_q < IW'(NINIT));
  // The next item is loaded in the cycle the current last write goes out.
  assign pipe_ready = !busy_q || (out_adv && is_last);
  assign take       = pipe_valid && pipe_ready;

  always_comb begin
    busy_d       = busy_q;
    idx_d        = idx_q;
    item_dig_d   = item_dig_q;
    item_shown_d = item_shown_q;
    item_flags_d = item_flags_q;
    if (emit) begin
      idx_d = idx_q + 1'b1;
      if (is_last) begin
        busy_d = 1'b0;
      end
      if (!is_init) begin
        item_dig_d   = item_dig_q >> 4;
        item_shown_d = item_shown_q >> 1;
      end
    end
    if (take) begin
      busy_d       = 1'b1;
      idx_d        = pipe_flags.show_init ? '0 : IW'(NINIT);
      item_dig_d   = pipe_digits;
      item_shown_d = pipe_shown;
      item_flags_d = pipe_flags;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_addr_d  = out_addr_q;
    out_data_d  = out_data_q;
    out_last_d  = out_last_q;
    if (out_adv) begin
      out_valid_d = busy_q;
      out_last_d  = is_last;
      if (is_init) begin
        out_addr_d = init_addr(idx_q[2:0]);
        out_data_d = init_data(idx_q[2:0]);
      end else begin
        out_addr_d = ADDR_W'(IW'(TOTAL) - idx_q);
        if (item_shown_q[0]) begin
          out_data_d = seg_code(item_dig_q[0]) |
                       (item_flags_q.with_dot ? DOT_BIT : '0);
        end else begin
          out_data_d = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_dig_q   <= item_dig_d;
    item_shown_q <= item_shown_d;
    item_flags_q <= item_flags_d;
    out_addr_q   <= out_addr_d;
    out_data_q   <= out_data_d;
    out_last_q   <= out_last_d;
  end

  assign out_valid_o   = out_valid_q;
  assign reg_address_o = out_addr_q;
  assign reg_data_o    = out_data_q;
  assign last_o        = out_last_q;

`ifndef ASSERT_OFF
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (idx_q < IW'(TOTAL)))
    else $error("write index beyond the last write of an item");

  a_take_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && busy_q) |-> (emit && is_last))
    else $error("new item loaded before the current item finished");

  a_init_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && is_init) |-> item_flags_q.show_init)
    else $error("control write issued in dotted mode");

  a_last_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_last_q) |-> (out_addr_q == ADDR_W'(1)))
    else $error("final write of an item is not the leftmost digit");
`endif

endmodule

[bench/segment_write_checker.sv]
`timescale 1ns / 100ps
// Checker for the number to seven-segment register write block: it predicts the
// register writes for every accepted item and compares them with the writes seen.
// Depends on ntsrw_pkg for widths, mode codes and register addresses.
module segment_write_checker import ntsrw_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  logic [31:0]       value_i,
  input  logic [1:0]        mode_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  logic [ADDR_W-1:0] reg_address_i,
  input  logic [DATA_W-1:0] reg_data_i,
  input  logic              last_i,
  output int                error_count_o,
  output int                pending_o
);

  localparam int DIGIT_COUNT = DIGITS_DEF;

  localparam logic [DATA_W-1:0] TEST_OFF        = 8'h00;
  localparam logic [DATA_W-1:0] SCAN_ALL_DIGITS = 8'h07;
  localparam logic [DATA_W-1:0] NO_DECODE       = 8'h00;
  localparam logic [DATA_W-1:0] NORMAL_MODE     = 8'h01;
  localparam logic [DATA_W-1:0] BLANK           = 8'h00;

  localparam logic [DATA_W-1:0] SEGMENTS [10] = '{
    8'h7E, 8'h30, 8'h6D, 8'h79, 8'h33, 8'h5B, 8'h5F, 8'h70, 8'h7F, 8'h7B
  };

  typedef struct packed {
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] data;
    logic              last;
  } reg_write_t;

  reg_write_t expected_writes [$];

  function automatic void push_write(input logic [ADDR_W-1:0] address,
                                     input logic [DATA_W-1:0] data, input logic last);
    reg_write_t w;
    w.address = address;
    w.data    = data;
    w.last    = last;
    expected_writes.push_back(w);
  endfunction

  // Mode 3 has no meaning of its own and falls through to the blanking case.
  function automatic void predict_writes(input logic [31:0] value, input logic [1:0] mode);
    logic [31:0]       rest;
    logic [DATA_W-1:0] seg;
    bit                dotted;
    bit                keep_zeros;
    bit                blanked;
    dotted     = (mode == MODE_DOT);
    keep_zeros = (mode == MODE_FULL);
    blanked    = 1'b0;
    rest       = value;
    if (!dotted) begin
      push_write(ADDR_TEST, TEST_OFF, 1'b0);
      push_write(ADDR_SCANLIM, SCAN_ALL_DIGITS, 1'b0);
      push_write(ADDR_DECODE, NO_DECODE, 1'b0);
      push_write(ADDR_INTENSITY, INTENSITY_VAL, 1'b0);
      push_write(ADDR_SHUTDOWN, NORMAL_MODE, 1'b0);
    end
    for (int pos = DIGIT_COUNT; pos >= 1; pos--) begin
      if (blanked) begin
        seg = BLANK;
      end else begin
        seg = SEGMENTS[4'(rest % 10)];
        if (dotted) seg = seg | DOT_BIT;
        rest = rest / 10;
        if (!keep_zeros && rest == 0) blanked = 1'b1;
      end
      push_write(ADDR_W'(pos), seg, pos == 1);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    reg_write_t want;
    if (!rst_ni) begin
      expected_writes.delete();
      error_count_o = 0;
      pending_o     = 0;
    end else begin
      if (in_valid_i && in_ready_i) predict_writes(value_i, mode_i);
      if (out_valid_i && out_ready_i) begin
        if (expected_writes.size() == 0) begin
          error_count_o++;
          $display("%0t: unexpected write addr %h data %h last %b", $time,
                   reg_address_i, reg_data_i, last_i);
        end else begin
          want = expected_writes.pop_front();
          if (reg_address_i !== want.address) begin
            error_count_o++;
            $display("%0t: reg_address expected %h actual %h", $time,
                     want.address, reg_address_i);
          end
          if (reg_data_i !== want.data) begin
            error_count_o++;
            $display("%0t: reg_data expected %h actual %h (addr %h)", $time,
                     want.data, reg_data_i, want.address);
          end
          if (last_i !== want.last) begin
            error_count_o++;
            $display("%0t: last expected %b actual %b (addr %h)", $time,
                     want.last, last_i, want.address);
          end
        end
      end
      pending_o = expected_writes.size();
    end
  end

endmodule

[bench/number_to_segment_register_writes_test.sv]
`timescale 1ns / 100ps
// Top of the testbench: clock, reset, number stimulus and write-side stalls for
// number_to_segment_register_writes. Depends on ntsrw_pkg and segment_write_checker.
module number_to_segment_register_writes_test;
  import ntsrw_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int RANDOM_ITEMS = 108;
  localparam int DRAIN_CYCLES = 40;

  localparam logic [1:0] MODE_UNUSED = 2'd3;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [31:0]       value = '0;
  logic [1:0]        mode = MODE_BLANK;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [ADDR_W-1:0] reg_address;
  logic [DATA_W-1:0] reg_data;
  logic              last;
  int                errors;
  int                pending;
  int                cycles = 0;
  bit                steady = 1'b0;

  always #5 clk = ~clk;

  number_to_segment_register_writes DUT (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .value_i      (value),
    .mode_i       (mode),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .reg_address_o(reg_address),
    .reg_data_o   (reg_data),
    .last_o       (last)
  );

  segment_write_checker checker_i (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .value_i      (value),
    .mode_i       (mode),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .reg_address_i(reg_address),
    .reg_data_i   (reg_data),
    .last_i       (last),
    .error_count_o(errors),
    .pending_o    (pending)
  );

  // Mostly short gaps, now and then a long one; none during a steady stretch.
  function automatic int next_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [31:0] random_number();
    logic [31:0] scale;
    int          digits;
    scale  = 32'd1;
    digits = $urandom_range(1, 9);
    for (int k = 0; k < digits; k++) scale = scale * 10;
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return $urandom_range(0, 9);
      2: return $urandom() % scale;
      3: return scale * $urandom_range(1, 4);
      4: return 32'd99_999_999 + $urandom_range(0, 4) - 2;
      default: return $urandom_range(100_000_000, 32'hFFFF_FFFF);
    endcase
  endfunction

  function automatic logic [1:0] random_mode();
    if ($urandom_range(0, 9) == 0) return MODE_UNUSED;
    return 2'($urandom_range(0, 2));
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance with
  // valid still high, so a back-to-back item never lowers it.
  task automatic send_number(input logic [31:0] number, input logic [1:0] number_mode);
    int gap;
    gap = next_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    value    <= number;
    mode     <= number_mode;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    int stall;
    forever begin
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      stall = next_gap();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_number(32'd0, MODE_BLANK);
    send_number(32'd0, MODE_FULL);
    send_number(32'd0, MODE_DOT);
    send_number(32'd0, MODE_UNUSED);
    send_number(32'hFFFF_FFFF, MODE_BLANK);
    send_number(32'hFFFF_FFFF, MODE_FULL);
    send_number(32'hFFFF_FFFF, MODE_DOT);
    send_number(32'hFFFF_FFFF, MODE_UNUSED);
    send_number(32'd1, MODE_DOT);
    send_number(32'd9, MODE_BLANK);
    send_number(32'd10, MODE_BLANK);
    send_number(32'd7, MODE_FULL);
    send_number(32'd12_345_678, MODE_FULL);
    send_number(32'd12_345_678, MODE_DOT);
    send_number(32'd99_999_999, MODE_BLANK);
    send_number(32'd100_000_000, MODE_BLANK);
    send_number(32'd100_000_000, MODE_DOT);
    send_number(32'd1_000_000_000, MODE_FULL);
    send_number(32'd1_000_000_000, MODE_BLANK);
    send_number(32'd10_000_001, MODE_DOT);
    send_number(32'hAAAA_AAAA, MODE_FULL);
    send_number(32'h5555_5555, MODE_DOT);
    wait_drained();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      steady = (i >= 30 && i < 55);
      if (i == 70) wait_drained();
      send_number(random_number(), random_mode());
    end
    steady = 1'b0;

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
